>>> src/hlv_pkg.sv
// ----------------------------------------------------------------------------
// hlv_pkg
// shared constants, queue item type and sine/cosine tables for the hough
// line accumulator
// ----------------------------------------------------------------------------
package hlv_pkg;

    localparam int ANGLE_STEPS     = 180;
    localparam int DISTANCE_BINS   = 1600;
    localparam int DISTANCE_OFFSET = 800;
    localparam int IMAGE_ROWS      = 480;
    localparam int IMAGE_COLS      = 640;

    localparam int ROW_W  = 9;
    localparam int COL_W  = 10;
    localparam int ANG_W  = 8;
    localparam int DIST_W = 11;
    localparam int CNT_W  = 19;

    localparam int BIN_TOTAL  = ANGLE_STEPS * DISTANCE_BINS;
    localparam int ADDR_W     = $clog2(BIN_TOTAL);
    localparam int STEP_W     = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
    localparam int DIST_IDX_W = $clog2(DISTANCE_BINS);

    localparam int DEG_W  = 9;
    localparam int Q_BITS = 16;
    localparam int TRIG_W = Q_BITS + 2;

    localparam int Q_PTR_W     = 2;
    localparam int QUEUE_DEPTH = 1 << Q_PTR_W;

    localparam logic [CNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(325);

    typedef enum logic {
        ACT_VOTE = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef struct packed {
        logic              is_read;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ADDR_W-1:0] addr;
        logic              addr_ok;
    } item_t;

    // round(sin(i deg) * 65536) for i = 0..90
    function automatic logic [Q_BITS:0] quarter_sine(input logic [6:0] i);
        logic [Q_BITS:0] q;
        case (i)
            7'd0:  q = 17'd0;     7'd1:  q = 17'd1144;  7'd2:  q = 17'd2287;
            7'd3:  q = 17'd3430;  7'd4:  q = 17'd4572;  7'd5:  q = 17'd5712;
            7'd6:  q = 17'd6850;  7'd7:  q = 17'd7987;  7'd8:  q = 17'd9121;
            7'd9:  q = 17'd10252; 7'd10: q = 17'd11380; 7'd11: q = 17'd12505;
            7'd12: q = 17'd13626; 7'd13: q = 17'd14742; 7'd14: q = 17'd15855;
            7'd15: q = 17'd16962; 7'd16: q = 17'd18064; 7'd17: q = 17'd19161;
            7'd18: q = 17'd20252; 7'd19: q = 17'd21336; 7'd20: q = 17'd22415;
            7'd21: q = 17'd23486; 7'd22: q = 17'd24550; 7'd23: q = 17'd25607;
            7'd24: q = 17'd26656; 7'd25: q = 17'd27697; 7'd26: q = 17'd28729;
            7'd27: q = 17'd29753; 7'd28: q = 17'd30767; 7'd29: q = 17'd31772;
            7'd30: q = 17'd32768; 7'd31: q = 17'd33754; 7'd32: q = 17'd34729;
            7'd33: q = 17'd35693; 7'd34: q = 17'd36647; 7'd35: q = 17'd37590;
            7'd36: q = 17'd38521; 7'd37: q = 17'd39441; 7'd38: q = 17'd40348;
            7'd39: q = 17'd41243; 7'd40: q = 17'd42126; 7'd41: q = 17'd42995;
            7'd42: q = 17'd43852; 7'd43: q = 17'd44695; 7'd44: q = 17'd45525;
            7'd45: q = 17'd46341; 7'd46: q = 17'd47143; 7'd47: q = 17'd47930;
            7'd48: q = 17'd48703; 7'd49: q = 17'd49461; 7'd50: q = 17'd50203;
            7'd51: q = 17'd50931; 7'd52: q = 17'd51643; 7'd53: q = 17'd52339;
            7'd54: q = 17'd53020; 7'd55: q = 17'd53684; 7'd56: q = 17'd54332;
            7'd57: q = 17'd54963; 7'd58: q = 17'd55578; 7'd59: q = 17'd56175;
            7'd60: q = 17'd56756; 7'd61: q = 17'd57319; 7'd62: q = 17'd57865;
            7'd63: q = 17'd58393; 7'd64: q = 17'd58903; 7'd65: q = 17'd59396;
            7'd66: q = 17'd59870; 7'd67: q = 17'd60326; 7'd68: q = 17'd60764;
            7'd69: q = 17'd61183; 7'd70: q = 17'd61584; 7'd71: q = 17'd61966;
            7'd72: q = 17'd62328; 7'd73: q = 17'd62672; 7'd74: q = 17'd62997;
            7'd75: q = 17'd63303; 7'd76: q = 17'd63589; 7'd77: q = 17'd63856;
            7'd78: q = 17'd64104; 7'd79: q = 17'd64332; 7'd80: q = 17'd64540;
            7'd81: q = 17'd64729; 7'd82: q = 17'd64898; 7'd83: q = 17'd65048;
            7'd84: q = 17'd65177; 7'd85: q = 17'd65287; 7'd86: q = 17'd65376;
            7'd87: q = 17'd65446; 7'd88: q = 17'd65496; 7'd89: q = 17'd65526;
            7'd90: q = 17'd65536;
            default: q = 17'd0;
        endcase
        return q;
    endfunction

    // signed q1.16 sine for angles 0..359 by quadrant symmetry
    function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [DEG_W-1:0] a);
        logic [DEG_W-1:0]          i;
        logic                      neg;
        logic signed [TRIG_W-1:0]  mag;
        if (a <= 9'd90) begin
            i   = a;
            neg = 1'b0;
        end else if (a <= 9'd180) begin
            i   = 9'd180 - a;
            neg = 1'b0;
        end else if (a <= 9'd270) begin
            i   = a - 9'd180;
            neg = 1'b1;
        end else begin
            i   = 9'd360 - a;
            neg = 1'b1;
        end
        mag = $signed({1'b0, quarter_sine(i[6:0])});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [TRIG_W-1:0] cosine_deg(input logic [DEG_W-1:0] a);
        logic [DEG_W:0] s;
        s = {1'b0, a} + 10'd90;
        if (s >= 10'd360) begin
            s = s - 10'd360;
        end
        return sine_deg(s[DEG_W-1:0]);
    endfunction

endpackage

>>> src/hough_line_voting.sv
// ----------------------------------------------------------------------------
// hough_line_voting
// hough line accumulator: edge pixel votes over all angles, bin readback
// ----------------------------------------------------------------------------
//  channel   direction   handshake              payload
//  in        input       in_valid / in_ready    action, pixel_row, pixel_col,
//                                               angle_index, distance_index
//  out       output      out_valid / out_ready  bin_count, above_threshold
//  cfg       input       cfg_valid / cfg_ready  vote_threshold
//
//  a vote runs one accumulator read-modify-write per angle over the single
//  memory port pair, plus a five-stage pipeline drain
//  a read waits while a previous result is still held
//  after reset a clearing pass writes all 288000 bins, one per cycle, with
//  in_ready low; the queue holds up to 4 requests while the engine is busy
// ----------------------------------------------------------------------------
module hough_line_voting (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [hlv_pkg::ROW_W-1:0]           pixel_row,
    input  logic [hlv_pkg::COL_W-1:0]           pixel_col,
    input  logic [hlv_pkg::ANG_W-1:0]           angle_index,
    input  logic [hlv_pkg::DIST_W-1:0]          distance_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hlv_pkg::CNT_W-1:0]           bin_count,
    output logic                                above_threshold,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hlv_pkg::CNT_W-1:0]           vote_threshold
);

    logic            clear_busy;
    logic            push;
    logic            push_ready;
    hlv_pkg::item_t  push_item;
    logic            q_valid;
    logic            q_pop;
    hlv_pkg::item_t  q_item;

    assign cfg_ready = 1'b1;

    hlv_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .pixel_row      (pixel_row),
        .pixel_col      (pixel_col),
        .angle_index    (angle_index),
        .distance_index (distance_index),
        .clear_busy     (clear_busy),
        .q_ready        (push_ready),
        .q_push         (push),
        .q_item         (push_item)
    );

    hlv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    hlv_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .cfg_valid       (cfg_valid),
        .cfg_data        (vote_threshold),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bin_count       (bin_count),
        .above_threshold (above_threshold),
        .clear_busy      (clear_busy)
    );

    // no request taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !(in_valid && in_ready))
        else $error("request accepted during clearing pass");

    // queue stays empty until the clearing pass ends
    a_queue_empty_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !q_valid)
        else $error("queue holds a request during clearing pass");

    // an empty bin never reports a line
    a_zero_not_above: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (bin_count == '0)) |-> !above_threshold)
        else $error("empty bin flagged above threshold");

endmodule

>>> src/hlv_front.sv
// ----------------------------------------------------------------------------
// hlv_front
// request classifier: drops votes outside the image, range checks reads and
// forms the flat bin address of a read
// ----------------------------------------------------------------------------
module hlv_front (
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [hlv_pkg::ROW_W-1:0]           pixel_row,
    input  logic [hlv_pkg::COL_W-1:0]           pixel_col,
    input  logic [hlv_pkg::ANG_W-1:0]           angle_index,
    input  logic [hlv_pkg::DIST_W-1:0]          distance_index,
    input  logic                                clear_busy,
    input  logic                                q_ready,
    output logic                                q_push,
    output hlv_pkg::item_t                      q_item
);

    localparam int AddrW = hlv_pkg::ADDR_W;

    logic is_read;
    logic vote_ok;
    logic read_ok;

    always_comb
    begin
        is_read = (action == hlv_pkg::ACT_READ);
        vote_ok = (32'(pixel_row) < hlv_pkg::IMAGE_ROWS)
               && (32'(pixel_col) < hlv_pkg::IMAGE_COLS);
        read_ok = (32'(angle_index) < hlv_pkg::ANGLE_STEPS)
               && (32'(distance_index) < hlv_pkg::DISTANCE_BINS);
    end

    assign in_ready = !clear_busy && q_ready;

    // votes outside the image are taken and dropped here
    assign q_push = in_valid && in_ready && (is_read || vote_ok);

    always_comb
    begin
        q_item.is_read = is_read;
        q_item.row     = pixel_row;
        q_item.col     = pixel_col;
        q_item.addr    = AddrW'(angle_index) * AddrW'(hlv_pkg::DISTANCE_BINS)
                       + AddrW'(distance_index);
        q_item.addr_ok = read_ok;
    end

endmodule

>>> src/hlv_queue.sv
// ----------------------------------------------------------------------------
// hlv_queue
// small request queue between the classifier and the voting engine
// ----------------------------------------------------------------------------
module hlv_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hlv_pkg::item_t  push_item,
    output logic            push_ready,
    output logic            q_valid,
    output hlv_pkg::item_t  q_item,
    input  logic            q_pop
);

    localparam int PtrW  = hlv_pkg::Q_PTR_W;
    localparam int Depth = hlv_pkg::QUEUE_DEPTH;

    hlv_pkg::item_t   entry_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]    fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != (PtrW + 1)'(Depth));
    assign q_valid    = (fill_reg != '0);
    assign q_item     = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/hlv_back.sv
// ----------------------------------------------------------------------------
// hlv_back
// voting engine: clearing pass, angle sequencer, rho pipeline,
// read-modify-write of the accumulator memory and the result register
// ----------------------------------------------------------------------------
module hlv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  hlv_pkg::item_t              q_item,
    output logic                        q_pop,
    input  logic                        cfg_valid,
    input  logic [hlv_pkg::CNT_W-1:0]   cfg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hlv_pkg::CNT_W-1:0]   bin_count,
    output logic                        above_threshold,
    output logic                        clear_busy
);

    localparam int AddrW = hlv_pkg::ADDR_W;
    localparam int StepW = hlv_pkg::STEP_W;
    localparam int CntW  = hlv_pkg::CNT_W;
    localparam int DegW  = hlv_pkg::DEG_W;
    localparam int TrigW = hlv_pkg::TRIG_W;
    localparam int RowW  = hlv_pkg::ROW_W;
    localparam int ColW  = hlv_pkg::COL_W;
    localparam int PrW   = RowW + 1 + TrigW;
    localparam int PcW   = ColW + 1 + TrigW;
    localparam int DiffW = PcW + 1;
    localparam int BinW  = DiffW - hlv_pkg::Q_BITS + 1;
    localparam int DistIdxW = hlv_pkg::DIST_IDX_W;
    localparam int QMask = (1 << hlv_pkg::Q_BITS) - 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOTE,
        ST_DRAIN,
        ST_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [AddrW-1:0]   clr_addr_reg, clr_addr_next;
    logic [StepW-1:0]   angle_reg, angle_next;
    logic [AddrW-1:0]   base_reg, base_next;
    logic [RowW-1:0]    row_reg, row_next;
    logic [ColW-1:0]    col_reg, col_next;
    logic [CntW-1:0]    thr_reg, thr_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic               above_reg, above_next;
    logic               s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;

    logic signed [TrigW-1:0]  s1_sin_reg, s1_cos_reg;
    logic [AddrW-1:0]         s1_base_reg;
    logic signed [PrW-1:0]    s2_pr_reg;
    logic signed [PcW-1:0]    s2_pc_reg;
    logic [AddrW-1:0]         s2_base_reg;
    logic signed [BinW-1:0]   s3_bin_reg;
    logic [AddrW-1:0]         s3_base_reg;
    logic [AddrW-1:0]         s4_addr_reg;
    logic [AddrW-1:0]         s5_addr_reg;

    logic signed [RowW:0]     row_s;
    logic signed [ColW:0]     col_s;
    logic signed [PrW-1:0]    pr_next;
    logic signed [PcW-1:0]    pc_next;
    logic signed [DiffW-1:0]  diff;
    logic signed [DiffW-1:0]  diff_adj;
    logic signed [BinW-1:0]   bin_next;
    logic                     bin_in_range;
    logic [AddrW-1:0]         addr_next;

    logic [CntW-1:0]    acc_mem [hlv_pkg::BIN_TOTAL];
    logic [CntW-1:0]    rd_data_reg;
    logic [AddrW-1:0]   rd_addr;
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr;
    logic [CntW-1:0]    wr_data;
    logic               pipe_busy;

    assign clear_busy      = (state_reg == ST_CLEAR);
    assign out_valid       = out_valid_reg;
    assign bin_count       = count_reg;
    assign above_threshold = above_reg;
    assign pipe_busy       = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg || s5_v_reg;

    // sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        angle_next     = angle_reg;
        base_next      = base_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rd_ok_next     = rd_ok_reg;
        count_next     = count_reg;
        above_next     = above_reg;
        out_valid_next = out_valid_reg;
        thr_next       = cfg_valid ? cfg_data : thr_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AddrW'(hlv_pkg::BIN_TOTAL - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.is_read)
                    begin
                        if (!out_valid_reg)
                        begin
                            q_pop      = 1'b1;
                            rd_ok_next = q_item.addr_ok;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        row_next   = q_item.row;
                        col_next   = q_item.col;
                        angle_next = '0;
                        base_next  = '0;
                        state_next = ST_VOTE;
                    end
                end
            end
            ST_VOTE:
            begin
                angle_next = angle_reg + 1'b1;
                base_next  = base_reg + AddrW'(hlv_pkg::DISTANCE_BINS);
                if (angle_reg == StepW'(hlv_pkg::ANGLE_STEPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                count_next     = rd_ok_reg ? rd_data_reg : '0;
                above_next     = (count_next > thr_reg);
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            angle_reg     <= '0;
            base_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            thr_reg       <= hlv_pkg::THRESHOLD_RESET;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            above_reg     <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            angle_reg     <= angle_next;
            base_reg      <= base_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            thr_reg       <= thr_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            above_reg     <= above_next;
            s1_v_reg      <= (state_reg == ST_VOTE);
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg && bin_in_range;
            s5_v_reg      <= s4_v_reg;
        end
    end

    // rho pipeline: table, products, truncation, bin address
    always_comb
    begin
        row_s    = $signed({1'b0, row_reg});
        col_s    = $signed({1'b0, col_reg});
        pr_next  = PrW'(row_s) * PrW'(s1_cos_reg);
        pc_next  = PcW'(col_s) * PcW'(s1_sin_reg);
        diff     = DiffW'(s2_pr_reg) - DiffW'(s2_pc_reg);
        // round toward zero on the q1.16 shift
        diff_adj = diff + (diff[DiffW-1] ? DiffW'(QMask) : DiffW'(0));
        bin_next = BinW'(diff_adj >>> hlv_pkg::Q_BITS) + BinW'(hlv_pkg::DISTANCE_OFFSET);
        bin_in_range = !s3_bin_reg[BinW-1]
                    && (s3_bin_reg < BinW'(hlv_pkg::DISTANCE_BINS));
        addr_next = s3_base_reg + AddrW'(s3_bin_reg[DistIdxW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        s1_sin_reg  <= hlv_pkg::sine_deg(DegW'(angle_reg));
        s1_cos_reg  <= hlv_pkg::cosine_deg(DegW'(angle_reg));
        s1_base_reg <= base_reg;
        s2_pr_reg   <= pr_next;
        s2_pc_reg   <= pc_next;
        s2_base_reg <= s1_base_reg;
        s3_bin_reg  <= bin_next;
        s3_base_reg <= s2_base_reg;
        s4_addr_reg <= addr_next;
        s5_addr_reg <= s4_addr_reg;
    end

    // accumulator memory, one read and one write port
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = q_item.addr_ok ? q_item.addr : '0;
        end
        else
        begin
            rd_addr = s4_addr_reg;
        end
        wr_en   = clear_busy || s5_v_reg;
        wr_addr = clear_busy ? clr_addr_reg : s5_addr_reg;
        if (clear_busy)
        begin
            wr_data = '0;
        end
        else if (rd_data_reg == hlv_pkg::COUNT_MAX)
        begin
            wr_data = rd_data_reg;
        end
        else
        begin
            wr_data = rd_data_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= acc_mem[rd_addr];
    end

endmodule

>>> verif/hough_line_voting_checker.sv
// ----------------------------------------------------------------------------
// hough_line_voting_checker
// watches the request, result and threshold channels of the hough line
// accumulator, keeps its own copy of the vote bins and the threshold, and
// compares every returned bin readback against the predicted count and flag
// ----------------------------------------------------------------------------
module hough_line_voting_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          action,
    input  logic [hlv_pkg::ROW_W-1:0]     pixel_row,
    input  logic [hlv_pkg::COL_W-1:0]     pixel_col,
    input  logic [hlv_pkg::ANG_W-1:0]     angle_index,
    input  logic [hlv_pkg::DIST_W-1:0]    distance_index,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [hlv_pkg::CNT_W-1:0]     bin_count,
    input  logic                          above_threshold,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [hlv_pkg::CNT_W-1:0]     vote_threshold,
    output int                            mismatch_count,
    output int                            reads_pending
);

    import hlv_pkg::*;

    localparam int     MAX_SHOWN = 10;
    localparam longint Q_ONE     = 64'sd1 << Q_BITS;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             above;
    } bin_readback_t;

    // round(sin(deg) * 2^16), deg = 0..90
    int sine_q16 [0:90] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    logic [CNT_W-1:0] bin_votes [int];
    logic [CNT_W-1:0] threshold_q;
    bin_readback_t    expected_reads [$];

    // angles stay within 0..179
    function automatic int sin_q16(input int deg);
        if (deg <= 90)
        begin
            return sine_q16[deg];
        end
        return sine_q16[180 - deg];
    endfunction

    function automatic int cos_q16(input int deg);
        if (deg <= 90)
        begin
            return sine_q16[90 - deg];
        end
        return -sine_q16[deg - 90];
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
        begin
            $display("hough_line_voting_checker: %s expected %0d got %0d at %0t",
                     what, want_v, got_v, $realtime);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        bin_readback_t want;
        longint        prod;
        longint        rho;
        int            slot;
        if (!rst_n)
        begin
            bin_votes.delete();
            expected_reads.delete();
            threshold_q    = THRESHOLD_RESET;
            mismatch_count = 0;
            reads_pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_q = vote_threshold;
            end

            if (in_valid && in_ready)
            begin
                if (action == ACT_VOTE)
                begin
                    // pixels outside the image cast no votes
                    if (pixel_row < IMAGE_ROWS && pixel_col < IMAGE_COLS)
                    begin
                        for (int deg = 0; deg < ANGLE_STEPS; deg++)
                        begin
                            prod = longint'(pixel_row) * cos_q16(deg)
                                 - longint'(pixel_col) * sin_q16(deg);
                            rho  = prod / Q_ONE + DISTANCE_OFFSET;
                            if (rho >= 0 && rho < DISTANCE_BINS)
                            begin
                                slot = deg * DISTANCE_BINS + int'(rho);
                                if (!bin_votes.exists(slot))
                                begin
                                    bin_votes[slot] = '0;
                                end
                                // saturating count
                                if (bin_votes[slot] != COUNT_MAX)
                                begin
                                    bin_votes[slot] = bin_votes[slot] + 1'b1;
                                end
                            end
                        end
                    end
                end
                else
                begin
                    want.count = '0;
                    if (angle_index < ANGLE_STEPS && distance_index < DISTANCE_BINS)
                    begin
                        slot = int'(angle_index) * DISTANCE_BINS + int'(distance_index);
                        if (bin_votes.exists(slot))
                        begin
                            want.count = bin_votes[slot];
                        end
                    end
                    want.above = (want.count > threshold_q);
                    expected_reads.push_back(want);
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    flag_mismatch("unrequested result, bin_count", 0, bin_count);
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (bin_count !== want.count)
                    begin
                        flag_mismatch("bin_count", want.count, bin_count);
                    end
                    if (above_threshold !== want.above)
                    begin
                        flag_mismatch("above_threshold", want.above, above_threshold);
                    end
                end
            end

            reads_pending = expected_reads.size();
        end
    end

endmodule

>>> verif/hough_line_voting_tb.sv
// ----------------------------------------------------------------------------
// hough_line_voting_tb
// drives edge pixel votes, bin reads and threshold writes into the hough
// line accumulator with random idle gaps and result back-pressure; a
// separate checker predicts every readback and counts mismatches
// ----------------------------------------------------------------------------
module hough_line_voting_tb;

    import hlv_pkg::*;

    localparam int  HALF_PERIOD     = 5;
    localparam int  RESET_CYCLES    = 4;
    localparam int  DRAIN_CYCLES    = 1000;
    localparam int  WATCHDOG_LIMIT  = 900000;
    localparam int  RANDOM_PHASES   = 7;
    localparam int  ITEMS_PER_PHASE = 100;
    localparam int  RECENT_DEPTH    = 16;
    localparam real PI              = 3.14159265358979323846;

    typedef enum int {
        LINE_ROW,
        LINE_COL,
        LINE_DIAG
    } line_shape_t;

    typedef struct {
        int row;
        int col;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [ROW_W-1:0]   pixel_row;
    logic [COL_W-1:0]   pixel_col;
    logic [ANG_W-1:0]   angle_index;
    logic [DIST_W-1:0]  distance_index;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CNT_W-1:0]   bin_count;
    logic               above_threshold;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CNT_W-1:0]   vote_threshold;

    int                 mismatch_count;
    int                 reads_pending;
    int                 quiet_cycles = 0;
    int                 out_stall = 0;
    bit                 in_steady = 1'b0;
    bit                 out_steady = 1'b0;
    pixel_t             recent_pixels [$];

    hough_line_voting DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .angle_index     (angle_index),
        .distance_index  (distance_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bin_count       (bin_count),
        .above_threshold (above_threshold),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .vote_threshold  (vote_threshold)
    );

    hough_line_voting_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .angle_index     (angle_index),
        .distance_index  (distance_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bin_count       (bin_count),
        .above_threshold (above_threshold),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .vote_threshold  (vote_threshold),
        .mismatch_count  (mismatch_count),
        .reads_pending   (reads_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    // result back-pressure
    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!out_steady)
            begin
                out_stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** hough_line_voting: FAILED **");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input action_t act, input int row, input int col,
                                input int deg, input int bin_idx);
        int gap;
        gap = in_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action         <= act;
        pixel_row      <= row[ROW_W-1:0];
        pixel_col      <= col[COL_W-1:0];
        angle_index    <= deg[ANG_W-1:0];
        distance_index <= bin_idx[DIST_W-1:0];
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // wait out all readbacks, then any votes still queued in the block
    task automatic settle_block();
        in_valid <= 1'b0;
        while (reads_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [CNT_W-1:0] value);
        cfg_valid      <= 1'b1;
        vote_threshold <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          roll;
        int          row;
        int          col;
        int          deg;
        int          bin_idx;
        int          hot_pos;
        action_t     act;
        line_shape_t hot_kind;
        real         rad;
        pixel_t      px;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_VOTE;
        pixel_row      = '0;
        pixel_col      = '0;
        angle_index    = '0;
        distance_index = '0;
        cfg_valid      = 1'b0;
        vote_threshold = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, image corners, pixels off the image, bin range edges
        send_request(ACT_READ, 0, 0, 0, DISTANCE_OFFSET);
        send_request(ACT_VOTE, 0, 0, 0, 0);
        send_request(ACT_VOTE, IMAGE_ROWS - 1, IMAGE_COLS - 1, 255, 2047);
        send_request(ACT_VOTE, IMAGE_ROWS - 1, 0, 0, 0);
        send_request(ACT_VOTE, 0, IMAGE_COLS - 1, 0, 0);
        send_request(ACT_VOTE, IMAGE_ROWS, 0, 0, 0);
        send_request(ACT_VOTE, 0, IMAGE_COLS, 0, 0);
        send_request(ACT_VOTE, 511, 1023, 0, 0);
        send_request(ACT_READ, 511, 1023, 0, DISTANCE_OFFSET);
        send_request(ACT_READ, 0, 0, 90, DISTANCE_OFFSET);
        send_request(ACT_READ, 0, 0, ANGLE_STEPS - 1, DISTANCE_OFFSET);
        send_request(ACT_READ, 0, 0, 0, DISTANCE_OFFSET + IMAGE_ROWS - 1);
        send_request(ACT_READ, 0, 0, 90, DISTANCE_OFFSET - IMAGE_COLS + 1);
        send_request(ACT_READ, 0, 0, 0, DISTANCE_BINS - 1);
        send_request(ACT_READ, 0, 0, ANGLE_STEPS - 1, 0);
        send_request(ACT_READ, 0, 0, ANGLE_STEPS, 0);
        send_request(ACT_READ, 0, 0, 0, DISTANCE_BINS);
        send_request(ACT_READ, 0, 0, 255, 2047);

        settle_block();
        write_threshold('0);
        send_request(ACT_READ, 0, 0, 0, DISTANCE_OFFSET);
        send_request(ACT_READ, 0, 0, 90, DISTANCE_OFFSET - IMAGE_COLS + 1);
        settle_block();
        write_threshold(COUNT_MAX);
        send_request(ACT_READ, 0, 0, 0, DISTANCE_OFFSET);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_block();
            case (phase)
                0:       write_threshold('0);
                1:       write_threshold(CNT_W'(3));
                2:       write_threshold(CNT_W'($urandom_range(0, 40)));
                3:       write_threshold(COUNT_MAX);
                4:       write_threshold(CNT_W'(1));
                5:       write_threshold(CNT_W'($urandom_range(0, 524287)));
                default: write_threshold(CNT_W'($urandom_range(5, 30)));
            endcase
            in_steady  = (phase == 1 || phase == 4 || phase == 6);
            out_steady = (phase == 2 || phase == 5 || phase == 6);

            // each phase builds up one line so its peak bin climbs
            hot_kind = line_shape_t'($urandom_range(0, 2));
            hot_pos  = (hot_kind == LINE_COL) ? $urandom_range(0, IMAGE_COLS - 1)
                                              : $urandom_range(0, IMAGE_ROWS - 1);

            repeat (ITEMS_PER_PHASE)
            begin
                roll    = $urandom_range(0, 99);
                act     = ACT_READ;
                row     = $urandom_range(0, 511);
                col     = $urandom_range(0, 1023);
                deg     = $urandom_range(0, 255);
                bin_idx = $urandom_range(0, 2047);
                if (roll < 32)
                begin
                    act = ACT_VOTE;
                    case (hot_kind)
                        LINE_ROW:
                        begin
                            row = hot_pos;
                            col = $urandom_range(0, IMAGE_COLS - 1);
                        end
                        LINE_COL:
                        begin
                            col = hot_pos;
                            row = $urandom_range(0, IMAGE_ROWS - 1);
                        end
                        default:
                        begin
                            row = $urandom_range(0, IMAGE_ROWS - 1);
                            col = row;
                        end
                    endcase
                end
                else if (roll < 42)
                begin
                    act = ACT_VOTE;
                    row = $urandom_range(0, IMAGE_ROWS - 1);
                    col = $urandom_range(0, IMAGE_COLS - 1);
                end
                else if (roll < 47)
                begin
                    // off the image
                    act = ACT_VOTE;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        row = $urandom_range(IMAGE_ROWS, 511);
                    end
                    else
                    begin
                        col = $urandom_range(IMAGE_COLS, 1023);
                    end
                end
                else if (roll < 62)
                begin
                    case (hot_kind)
                        LINE_ROW:
                        begin
                            deg     = 0;
                            bin_idx = DISTANCE_OFFSET + hot_pos;
                        end
                        LINE_COL:
                        begin
                            deg     = 90;
                            bin_idx = DISTANCE_OFFSET - hot_pos;
                        end
                        default:
                        begin
                            deg     = 45;
                            bin_idx = DISTANCE_OFFSET;
                        end
                    endcase
                    if ($urandom_range(0, 3) == 0)
                    begin
                        bin_idx = bin_idx + (($urandom_range(0, 1) == 1) ? 1 : -1);
                    end
                end
                else if (roll < 90 && recent_pixels.size() != 0)
                begin
                    // aim near the bin a recent pixel voted into
                    px      = recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
                    deg     = $urandom_range(0, ANGLE_STEPS - 1);
                    rad     = deg * PI / 180.0;
                    bin_idx = DISTANCE_OFFSET + $rtoi(px.row * $cos(rad) - px.col * $sin(rad))
                            + int'($urandom_range(0, 2)) - 1;
                end

                if (act == ACT_VOTE && row < IMAGE_ROWS && col < IMAGE_COLS)
                begin
                    px.row = row;
                    px.col = col;
                    recent_pixels.push_back(px);
                    if (recent_pixels.size() > RECENT_DEPTH)
                    begin
                        px = recent_pixels.pop_front();
                    end
                end
                send_request(act, row, col, deg, bin_idx);
            end
        end

        settle_block();
        if (mismatch_count == 0 && reads_pending == 0)
        begin
            $display("** hough_line_voting: PASSED **");
        end
        else
        begin
            $display("** hough_line_voting: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
src/hlv_pkg.sv
src/hlv_front.sv
src/hlv_queue.sv
src/hlv_back.sv
src/hough_line_voting.sv
verif/hough_line_voting_checker.sv
verif/hough_line_voting_tb.sv
